// ===== design/ssew_pkg.sv =====
package ssew_pkg;

	localparam int OUT_DIGITS = 4;

	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_J        = 8'h4A;
	localparam logic [7:0] CH_M        = 8'h6D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_NL       = 8'h0A;

	localparam logic [3:0] SEQ_CLEAR     = 4'd2;
	localparam logic [3:0] SEQ_BLINK_OFF = 4'd0;
	localparam logic [3:0] SEQ_BLINK_ON  = 4'd5;

	localparam logic [7:0] SEGMENTDP = 8'h01;

	typedef struct packed {
		logic [7:0] char_code;
		logic [7:0] glyph;
	} item_t;

	typedef struct packed {
		logic [OUT_DIGITS-1:0][7:0] steady;
		logic [OUT_DIGITS-1:0][7:0] alt;
	} result_t;

endpackage

// ===== design/ssew_if.sv =====
interface ssew_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic [7:0] glyph;

	modport source (output valid, output char_code, output glyph, input ready);
	modport sink (input valid, input char_code, input glyph, output ready);
endinterface

interface ssew_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] steady0;
	logic [7:0] steady1;
	logic [7:0] steady2;
	logic [7:0] steady3;
	logic [7:0] alt0;
	logic [7:0] alt1;
	logic [7:0] alt2;
	logic [7:0] alt3;

	modport source (
		output valid, input ready,
		output steady0, output steady1, output steady2, output steady3,
		output alt0, output alt1, output alt2, output alt3
	);
	modport sink (
		input valid, output ready,
		input steady0, input steady1, input steady2, input steady3,
		input alt0, input alt1, input alt2, input alt3
	);
endinterface

// ===== design/ssew_in_stage.sv =====
module ssew_in_stage
	import ssew_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	ssew_in_if.sink in_ch,
	input  logic   take,
	output logic   valid_s1,
	output item_t  item_s1
);

	logic accept;

	assign in_ch.ready = !valid_s1 || take;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.char_code <= in_ch.char_code;
			item_s1.glyph     <= in_ch.glyph;
		end
	end

endmodule

// ===== design/ssew_core.sv =====
module ssew_core
	import ssew_pkg::*;
#(
	parameter int NUM_DIGITS = 4
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  item_t   item_s1,
	input  logic    out_room,
	output logic    take,
	output logic    res_valid,
	output result_t res
);

	localparam int CW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [CW-1:0] LAST = CW'(NUM_DIGITS - 1);

	localparam logic [1:0] PS_GROUND  = 2'd0;
	localparam logic [1:0] PS_ESC     = 2'd1;
	localparam logic [1:0] PS_BRACKET = 2'd2;
	localparam logic [1:0] PS_DIGIT   = 2'd3;

	logic [1:0]    parse_q;
	logic [3:0]    seq_digit_q;
	logic          blink_on_q;
	logic [CW-1:0] cursor_q;
	logic [7:0]    steady_q [NUM_DIGITS];
	logic [7:0]    alt_q [NUM_DIGITS];

	logic [7:0]    c;
	logic          is_nl;
	logic          is_digit;
	logic          is_letter;
	logic          is_print;
	logic          is_dot;
	logic          do_write;
	logic          do_clear;
	logic [CW-1:0] cur_back;
	logic [CW-1:0] wr_idx;
	logic [7:0]    wr_val;

	assign c = item_s1.char_code;

	always_comb begin
		is_digit  = c inside {[8'h30:8'h39]};
		is_letter = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
		is_print  = c inside {[8'h20:8'h7E]};
	end

	assign is_nl     = (parse_q == PS_GROUND) && (c == CH_NL);
	assign is_dot    = (c == CH_DOT);
	assign take      = valid_s1 && (!is_nl || out_room);
	assign res_valid = take && is_nl;
	assign do_write  = take && (parse_q == PS_GROUND) && is_print;
	assign do_clear  = take && (parse_q == PS_DIGIT) && (c == CH_J) &&
		(seq_digit_q == SEQ_CLEAR);

	assign cur_back = (cursor_q != '0) ? cursor_q - CW'(1) : cursor_q;
	assign wr_idx   = is_dot ? cur_back : cursor_q;
	assign wr_val   = is_dot ? (steady_q[cur_back] | SEGMENTDP) : item_s1.glyph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q     <= PS_GROUND;
			seq_digit_q <= '0;
			blink_on_q  <= 1'b0;
		end else if (take) begin
			case (parse_q)
				PS_GROUND: begin
					if (c == CH_ESC) begin
						parse_q <= PS_ESC;
					end
				end
				PS_ESC: begin
					parse_q <= (c == CH_LBRACKET) ? PS_BRACKET : PS_GROUND;
				end
				PS_BRACKET: begin
					if (is_digit) begin
						seq_digit_q <= c[3:0];
						parse_q     <= PS_DIGIT;
					end else begin
						parse_q <= PS_GROUND;
					end
				end
				PS_DIGIT: begin
					if (is_letter) begin
						if (c == CH_M && seq_digit_q == SEQ_BLINK_OFF) begin
							blink_on_q <= 1'b0;
						end
						if (c == CH_M && seq_digit_q == SEQ_BLINK_ON) begin
							blink_on_q <= 1'b1;
						end
						parse_q <= PS_GROUND;
					end
				end
				default: begin
					parse_q <= PS_GROUND;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				steady_q[i] <= '0;
				alt_q[i]    <= '0;
			end
		end else if (do_clear) begin
			cursor_q <= '0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				steady_q[i] <= '0;
				alt_q[i]    <= '0;
			end
		end else if (do_write) begin
			steady_q[wr_idx] <= wr_val;
			if (!blink_on_q) begin
				alt_q[wr_idx] <= wr_val;
			end
			cursor_q <= (wr_idx == LAST) ? '0 : wr_idx + CW'(1);
		end
	end

	for (genvar j = 0; j < OUT_DIGITS; j++) begin : g_out
		if (j < NUM_DIGITS) begin : g_used
			assign res.steady[j] = steady_q[j];
			assign res.alt[j]    = alt_q[j];
		end else begin : g_blank
			assign res.steady[j] = '0;
			assign res.alt[j]    = '0;
		end
	end

endmodule

// ===== design/ssew_out_stage.sv =====
module ssew_out_stage
	import ssew_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     res_valid,
	input  result_t  res,
	output logic     out_room,
	ssew_out_if.source out_ch
);

	logic    valid_q;
	result_t res_q;

	assign out_room = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_room) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_room && res_valid) begin
			res_q <= res;
		end
	end

	assign out_ch.valid   = valid_q;
	assign out_ch.steady0 = res_q.steady[0];
	assign out_ch.steady1 = res_q.steady[1];
	assign out_ch.steady2 = res_q.steady[2];
	assign out_ch.steady3 = res_q.steady[3];
	assign out_ch.alt0    = res_q.alt[0];
	assign out_ch.alt1    = res_q.alt[1];
	assign out_ch.alt2    = res_q.alt[2];
	assign out_ch.alt3    = res_q.alt[3];

endmodule

// ===== design/seven_segment_escape_writer.sv =====
// channel  | direction | word
// ---------+-----------+-----------------------------------------------
// in_ch    | sink      | char_code, glyph
// out_ch   | source    | steady0..steady3, alt0..alt3 (one per newline outside escapes)
//
// One word per cycle sustained while no newline waits on a full output register.
// The character register and the output register each decouple one side.
// arst_n clears parser, blink, cursor and segment store to their idle values.
// A newline waits in the character register while the output register is full.
module seven_segment_escape_writer
	import ssew_pkg::*;
#(
	parameter int NUM_DIGITS = 4
)
(
	input  logic       clk,
	input  logic       arst_n,
	ssew_in_if.sink    in_ch,
	ssew_out_if.source out_ch
);

	logic    take;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_room;
	logic    res_valid;
	result_t res;

	ssew_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ssew_core #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_room  (out_room),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	ssew_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_room  (out_room),
		.out_ch    (out_ch)
	);

endmodule
